// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the median filter rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the rising clock edge, muted while reset is asserted
`define SWM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("swm assertion failed");

// implication whose consequent is checked in the cycle after the condition
`define SWM_ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("swm assertion failed");

`endif

// ----- hw/rtl/swm_pkg.sv -----
// ---------------------------------------------------------------------------
// swm_pkg
// types and constants shared by the median filter controller and datapath
// ---------------------------------------------------------------------------
package swm_pkg;

	// configuration register
	localparam int WIN_WIDTH = 7;
	localparam logic [WIN_WIDTH-1:0] WIN_RESET = 7'd3;
	localparam logic REG_WINDOW_SIZE = 1'b0;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_REMOVE = 4'b0010,
		ST_INSERT = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;   // capture a word, access the history ring
		logic remove;   // retire one copy of the oldest sample
		logic insert;   // place the new sample in sorted order
		logic load_out; // move the median into the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full; // window is full before the next word
		logic emit; // word in flight gives a result
	} status_t;

endpackage

// ----- hw/rtl/swm_ctrl.sv -----
// ---------------------------------------------------------------------------
// swm_ctrl
// sequencer for one word: capture, remove, insert, emit
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module swm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  swm_pkg::status_t status,
	output swm_pkg::cmd_t    cmd
);

	swm_pkg::state_t state_q, state_d;
	logic            out_valid_q;

	assign in_ready = (state_q == swm_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			swm_pkg::ST_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = status.full ? swm_pkg::ST_REMOVE : swm_pkg::ST_INSERT;
				end
			end
			swm_pkg::ST_REMOVE: begin
				cmd.remove = 1'b1;
				state_d = swm_pkg::ST_INSERT;
			end
			swm_pkg::ST_INSERT: begin
				cmd.insert = 1'b1;
				state_d = status.emit ? swm_pkg::ST_EMIT : swm_pkg::ST_IDLE;
			end
			swm_pkg::ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d = swm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = swm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swm_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// an accepted word always takes the controller out of idle in the next cycle
	`SWM_ASSERT_NEXT(a_accept_busy, clk, arst_n, cmd.accept, state_q != swm_pkg::ST_IDLE)
	// a waiting result is never overwritten
	`SWM_ASSERT(a_no_overwrite, clk, arst_n, cmd.load_out |-> (!out_valid_q || out_ready))
	// a result is only loaded after an insert step
	`SWM_ASSERT(a_load_after_insert, clk, arst_n,
		cmd.load_out |-> (status.emit && state_q == swm_pkg::ST_EMIT))

endmodule

// ----- hw/rtl/swm_datapath.sv -----
// ---------------------------------------------------------------------------
// swm_datapath
// history ring memory, row of sorted cells, counters and output register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module swm_datapath #(
	parameter int MAX_WINDOW   = 64,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  swm_pkg::cmd_t                  cmd,
	output swm_pkg::status_t               status,
	input  logic [SAMPLE_WIDTH-1:0]        sample,
	input  logic                           cfg_wr,
	input  logic [swm_pkg::WIN_WIDTH-1:0]  cfg_data,
	output logic [swm_pkg::WIN_WIDTH-1:0]  window_size,
	output logic [SAMPLE_WIDTH-1:0]        median
);

	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW = $clog2(MAX_WINDOW + 1);

	logic [swm_pkg::WIN_WIDTH-1:0] win_q;
	logic [CW-1:0]                 fill_q;
	logic [AW-1:0]                 op_q;
	logic                          emit_q;
	logic [CW-1:0]                 ins_cnt_q;
	logic [SAMPLE_WIDTH-1:0]       smp_q;
	logic [SAMPLE_WIDTH-1:0]       old_q;
	logic [SAMPLE_WIDTH-1:0]       med_q;

	logic [SAMPLE_WIDTH-1:0] ring_mem [MAX_WINDOW];
	logic [SAMPLE_WIDTH-1:0] cell_q [MAX_WINDOW];

	logic [CW-1:0]   eff_w;
	logic            full;
	logic [CW:0]     wr_sum;
	logic [AW-1:0]   wr_addr;
	logic [AW-1:0]   op_next;
	logic [CW-1:0]   mid;
	logic [MAX_WINDOW-1:0] gt;
	logic [MAX_WINDOW-1:0] ge_old;

	// a zero register acts as one, anything above the depth as the depth
	always_comb begin
		if (win_q == '0) begin
			eff_w = CW'(1);
		end else if (32'(win_q) > MAX_WINDOW) begin
			eff_w = CW'(MAX_WINDOW);
		end else begin
			eff_w = CW'(win_q);
		end
	end

	assign full = (fill_q >= eff_w);
	assign status.full = full;
	assign status.emit = emit_q;

	// ring write slot: after the newest sample while filling, the oldest sample's slot once full
	assign wr_sum = (CW+1)'(op_q) + (CW+1)'(fill_q);
	always_comb begin
		if (full) begin
			wr_addr = op_q;
		end else if (wr_sum >= (CW+1)'(eff_w)) begin
			wr_addr = AW'(wr_sum - (CW+1)'(eff_w));
		end else begin
			wr_addr = AW'(wr_sum);
		end
		if ((CW'(op_q) + CW'(1)) >= eff_w) begin
			op_next = '0;
		end else begin
			op_next = op_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= swm_pkg::WIN_RESET;
			fill_q <= '0;
			op_q <= '0;
			emit_q <= 1'b0;
		end else if (cfg_wr) begin
			win_q <= cfg_data;
			fill_q <= '0;
			op_q <= '0;
		end else if (cmd.accept) begin
			emit_q <= full || ((fill_q + CW'(1)) == eff_w);
			if (full) begin
				op_q <= op_next;
			end else begin
				fill_q <= fill_q + CW'(1);
			end
		end
	end

	// history ring: oldest sample read before the same slot is overwritten
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ring_mem[wr_addr] <= sample;
			old_q <= ring_mem[op_q];
			smp_q <= sample;
			ins_cnt_q <= full ? (eff_w - CW'(1)) : fill_q;
		end
	end

	// sorted cells: remove shifts down from the first copy, insert shifts up
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		logic [SAMPLE_WIDTH-1:0] ins_val;
		logic [SAMPLE_WIDTH-1:0] rem_val;
		logic                    rem_en;

		assign gt[i] = (CW'(i) < ins_cnt_q) && ($signed(cell_q[i]) > $signed(smp_q));
		assign ge_old[i] = ($signed(cell_q[i]) >= $signed(old_q));

		if (i > 0) begin : g_lo
			assign ins_val = gt[i-1] ? cell_q[i-1] : smp_q;
		end else begin : g_first
			assign ins_val = smp_q;
		end

		if (i < MAX_WINDOW - 1) begin : g_hi
			assign rem_val = cell_q[i+1];
			assign rem_en = (CW'(i + 1) < eff_w) && ge_old[i];
		end else begin : g_last
			assign rem_val = cell_q[i];
			assign rem_en = 1'b0;
		end

		always_ff @(posedge clk) begin
			if (cmd.remove && rem_en) begin
				cell_q[i] <= rem_val;
			end else if (cmd.insert && (gt[i] || (CW'(i) == ins_cnt_q))) begin
				cell_q[i] <= ins_val;
			end
		end
	end

	assign mid = (eff_w - CW'(1)) >> 1;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			med_q <= cell_q[mid[AW-1:0]];
		end
	end

	assign window_size = win_q;
	assign median = med_q;

	`SWM_ASSERT(a_fill_bound, clk, arst_n, fill_q <= eff_w)
	`SWM_ASSERT(a_ptr_bound, clk, arst_n, CW'(op_q) < eff_w)
	`SWM_ASSERT_NEXT(a_full_wraps, clk, arst_n, cmd.accept && full && !cfg_wr,
		fill_q == $past(fill_q))

endmodule

// ----- hw/rtl/sliding_window_median_unit.sv -----
// ---------------------------------------------------------------------------
// sliding_window_median_unit
// lower median over the most recent window_size signed samples
// ---------------------------------------------------------------------------
//
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    s_tdata: sample
// m_*       out  m_tvalid/m_tready    m_tdata: median
// apb       in   psel&penable&pwrite  window_size at byte address 0
//
// an item passes through capture and insert while filling, capture, insert and emit when it
// completes the window, and capture, remove, insert and emit once full, as set by the ring read
// and the separate remove and insert passes over the cells
// the emit step waits while the previous result has not been taken
// s_tready is high only in the idle step; a result waiting on m_* does not block it
// reset gives window_size 3 and an empty window; a window_size write empties it
// ---------------------------------------------------------------------------
module sliding_window_median_unit #(
	parameter int MAX_WINDOW   = 64,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// sample stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,  // sample
	// median stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,  // median
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	localparam int DW = ((SAMPLE_WIDTH + 7) / 8) * 8;

	swm_pkg::cmd_t                 cmd;
	swm_pkg::status_t              status;
	logic                          cfg_wr;
	logic [swm_pkg::WIN_WIDTH-1:0] window_size;
	logic [SAMPLE_WIDTH-1:0]       median;

	// register decode on the word index, byte offset ignored
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == swm_pkg::REG_WINDOW_SIZE);
	assign prdata = (paddr[2] == swm_pkg::REG_WINDOW_SIZE) ? 32'(window_size) : '0;

	swm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	swm_datapath #(
		.MAX_WINDOW   (MAX_WINDOW),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.sample      (s_tdata[SAMPLE_WIDTH-1:0]),
		.cfg_wr      (cfg_wr),
		.cfg_data    (pwdata[swm_pkg::WIN_WIDTH-1:0]),
		.window_size (window_size),
		.median      (median)
	);

	// median zero-filled up to whole bytes
	assign m_tdata = DW'(median);

endmodule
